>>> src/lqse_pkg.sv
// Shared constants for the logit quote spread engine.
// No dependencies; imported by the pipeline modules.
`default_nettype none

package lqse_pkg;

    // Width of every Q.F word at the ports.
    localparam int WORD_W = 32;

    // Internal fraction width of the sigmoid polynomial.
    localparam int Q24 = 24;

    // ln(2) in unsigned Q0.32.
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    // Log2 mantissa (Q1.30), fraction bits produced by squaring, exponent width.
    localparam int MANT_W   = 31;
    localparam int SQ_STEPS = 32;
    localparam int EXP_W    = 6;

    // Pade 7/6 tanh coefficients.
    localparam int PADE_N0 = 378;
    localparam int PADE_N1 = 17325;
    localparam int PADE_N2 = 135135;
    localparam int PADE_D0 = 3150;
    localparam int PADE_D1 = 62370;
    localparam int PADE_D2 = 135135;
    localparam int PADE_DZ = 28;

    // Sigmoid argument clip, integer part.
    localparam int CLIP_INT = 10;

endpackage

`default_nettype wire

>>> src/lqse_div.sv
// Pipelined restoring divider, one quotient bit per stage, with side payload.
// Standalone; used by the engine top level and the sigmoid.
`default_nettype none

module lqse_div #(
    parameter int NW = 32,
    parameter int DW = 32,
    parameter int PW = 1
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          ce,
    input  wire logic          in_valid,
    input  wire logic [NW-1:0] in_num,
    input  wire logic [DW-1:0] in_den,
    input  wire logic [PW-1:0] in_pay,
    output logic               out_valid,
    output logic [NW-1:0]      out_quo,
    output logic [PW-1:0]      out_pay
);

    logic [DW-1:0] rem_reg [NW];
    logic [NW-1:0] nq_reg  [NW];
    logic [DW-1:0] den_reg [NW];
    logic [PW-1:0] pay_reg [NW];
    logic          vld_reg [NW];

    for (genvar i = 0; i < NW; i++) begin : g_stage
        logic [DW-1:0] rem_in;
        logic [NW-1:0] nq_in;
        logic [DW-1:0] den_in;
        logic [PW-1:0] pay_in;
        logic          vld_in;
        logic [DW:0]   trial;
        logic          fits;

        if (i == 0) begin : g_head
            assign rem_in = '0;
            assign nq_in  = in_num;
            assign den_in = in_den;
            assign pay_in = in_pay;
            assign vld_in = in_valid;
        end else begin : g_body
            assign rem_in = rem_reg[i-1];
            assign nq_in  = nq_reg[i-1];
            assign den_in = den_reg[i-1];
            assign pay_in = pay_reg[i-1];
            assign vld_in = vld_reg[i-1];
        end

        // Shift in the next numerator bit and try to subtract the divisor.
        assign trial = {rem_in, nq_in[NW-1]};
        assign fits  = (trial >= {1'b0, den_in});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (ce) begin
                vld_reg[i] <= vld_in;
            end
        end

        // The numerator shifts out at the top while quotient bits enter below.
        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[i] <= fits ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
                nq_reg[i]  <= {nq_in[NW-2:0], fits};
                den_reg[i] <= den_in;
                pay_reg[i] <= pay_in;
            end
        end
    end

    assign out_valid = vld_reg[NW-1];
    assign out_quo   = nq_reg[NW-1];
    assign out_pay   = pay_reg[NW-1];

endmodule

`default_nettype wire

>>> src/lqse_log1p.sv
// Pipelined log1p: normalizes 1 + ratio, squares out 32 log2 fraction bits,
// scales by ln2 and rounds to Q.F. Depends on lqse_pkg.
`default_nettype none

module lqse_log1p
    import lqse_pkg::*;
#(
    parameter int FRAC_BITS = 20,
    parameter int PW        = 1
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 ce,
    input  wire logic                 in_valid,
    input  wire logic [FRAC_BITS+30:0] in_ratio,
    input  wire logic [PW-1:0]        in_pay,
    output logic                      out_valid,
    output logic [FRAC_BITS+6:0]      out_lp,
    output logic [PW-1:0]             out_pay
);

    localparam int RW  = FRAC_BITS + 31;
    localparam int UW  = RW + 1;
    localparam int LB  = $clog2(UW);
    localparam int LPW = FRAC_BITS + 7;
    localparam int LQW = 39;

    // Stage: u = ratio + 1.0
    logic [UW-1:0] u_reg;
    logic [PW-1:0] pay_u_reg;
    logic          vld_u_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_u_reg <= 1'b0;
        end else if (ce) begin
            vld_u_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            u_reg     <= UW'(in_ratio) + (UW'(1) << FRAC_BITS);
            pay_u_reg <= in_pay;
        end
    end

    // Leading-zero normalization, one binary step per stage.
    logic [UW-1:0] nrm_reg [LB];
    logic [LB-1:0] lz_reg  [LB];
    logic [PW-1:0] pay_n_reg [LB];
    logic          vld_n_reg [LB];

    for (genvar j = 0; j < LB; j++) begin : g_norm
        localparam int SH = 2 ** (LB - 1 - j);
        logic [UW-1:0] nrm_in;
        logic [LB-1:0] lz_in;
        logic [PW-1:0] pay_in;
        logic          vld_in;

        if (j == 0) begin : g_head
            assign nrm_in = u_reg;
            assign lz_in  = '0;
            assign pay_in = pay_u_reg;
            assign vld_in = vld_u_reg;
        end else begin : g_body
            assign nrm_in = nrm_reg[j-1];
            assign lz_in  = lz_reg[j-1];
            assign pay_in = pay_n_reg[j-1];
            assign vld_in = vld_n_reg[j-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_n_reg[j] <= 1'b0;
            end else if (ce) begin
                vld_n_reg[j] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                if (nrm_in[UW-1 -: SH] == '0) begin
                    nrm_reg[j] <= nrm_in << SH;
                    lz_reg[j]  <= lz_in + LB'(SH);
                end else begin
                    nrm_reg[j] <= nrm_in;
                    lz_reg[j]  <= lz_in;
                end
                pay_n_reg[j] <= pay_in;
            end
        end
    end

    // Repeated squaring of the Q1.30 mantissa, one fraction bit per stage.
    logic [MANT_W-1:0]   m_reg   [SQ_STEPS];
    logic [SQ_STEPS-1:0] fp_reg  [SQ_STEPS];
    logic [EXP_W-1:0]    ef_reg  [SQ_STEPS];
    logic [PW-1:0]       pay_s_reg [SQ_STEPS];
    logic                vld_s_reg [SQ_STEPS];

    for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sq
        logic [MANT_W-1:0]   m_in;
        logic [SQ_STEPS-1:0] fp_in;
        logic [EXP_W-1:0]    ef_in;
        logic [PW-1:0]       pay_in;
        logic                vld_in;
        logic [2*MANT_W-1:0] sq;
        logic [MANT_W:0]     sq_top;

        if (i == 0) begin : g_head
            // Exponent above the binary point of 1.0 is 31 - leading zeros.
            assign m_in   = nrm_reg[LB-1][UW-1 -: MANT_W];
            assign fp_in  = '0;
            assign ef_in  = EXP_W'(31) - EXP_W'(lz_reg[LB-1]);
            assign pay_in = pay_n_reg[LB-1];
            assign vld_in = vld_n_reg[LB-1];
        end else begin : g_body
            assign m_in   = m_reg[i-1];
            assign fp_in  = fp_reg[i-1];
            assign ef_in  = ef_reg[i-1];
            assign pay_in = pay_s_reg[i-1];
            assign vld_in = vld_s_reg[i-1];
        end

        assign sq     = (2*MANT_W)'(m_in) * (2*MANT_W)'(m_in);
        assign sq_top = sq[2*MANT_W-1:MANT_W-1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_s_reg[i] <= 1'b0;
            end else if (ce) begin
                vld_s_reg[i] <= vld_in;
            end
        end

        // A square at or above 2.0 yields a one bit and is halved.
        always_ff @(posedge aclk) begin
            if (ce) begin
                m_reg[i]     <= sq_top[MANT_W] ? sq_top[MANT_W:1] : sq_top[MANT_W-1:0];
                fp_reg[i]    <= {fp_in[SQ_STEPS-2:0], sq_top[MANT_W]};
                ef_reg[i]    <= ef_in;
                pay_s_reg[i] <= pay_in;
            end
        end
    end

    // Scale integer and fraction parts of log2 by ln2.
    logic [31:0]   frac_ln_reg;
    logic [37:0]   int_ln_reg;
    logic [PW-1:0] pay_a_reg;
    logic          vld_a_reg;
    logic [63:0]   frac_prod;

    assign frac_prod = 64'(fp_reg[SQ_STEPS-1]) * 64'(LN2_Q32) + 64'h8000_0000;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_a_reg <= 1'b0;
        end else if (ce) begin
            vld_a_reg <= vld_s_reg[SQ_STEPS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            frac_ln_reg <= frac_prod[63:32];
            int_ln_reg  <= 38'(ef_reg[SQ_STEPS-1]) * 38'(LN2_Q32);
            pay_a_reg   <= pay_s_reg[SQ_STEPS-1];
        end
    end

    // Round the Q.32 logarithm to nearest Q.F.
    logic [LQW-1:0] lq_sum;
    logic [LQW-1:0] lq_rnd;
    logic [LPW-1:0] lp_reg;
    logic [PW-1:0]  pay_b_reg;
    logic           vld_b_reg;

    assign lq_sum = LQW'(int_ln_reg) + LQW'(frac_ln_reg);
    assign lq_rnd = (lq_sum + (LQW'(1) << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_b_reg <= 1'b0;
        end else if (ce) begin
            vld_b_reg <= vld_a_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            lp_reg    <= lq_rnd[LPW-1:0];
            pay_b_reg <= pay_a_reg;
        end
    end

    assign out_valid = vld_b_reg;
    assign out_lp    = lp_reg;
    assign out_pay   = pay_b_reg;

endmodule

`default_nettype wire

>>> src/lqse_sigmoid.sv
// Pipelined Pade 7/6 tanh sigmoid from signed Q.F to unsigned Q0.32.
// Depends on lqse_pkg and lqse_div.
`default_nettype none

module lqse_sigmoid
    import lqse_pkg::*;
#(
    parameter int FRAC_BITS = 20
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        ce,
    input  wire logic        in_valid,
    input  wire logic [31:0] in_arg,
    output logic             out_valid,
    output logic [31:0]      out_prob
);

    localparam int SL  = (FRAC_BITS <= 23) ? 23 - FRAC_BITS : 0;
    localparam int SR  = (FRAC_BITS > 23) ? FRAC_BITS - 23 : 0;
    localparam int QNW = 63;
    localparam int QDW = 31;
    localparam int NST = 9;

    logic vld_reg [NST];

    // Valid bits of the polynomial stages.
    for (genvar i = 0; i < NST; i++) begin : g_vld
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (ce) begin
                vld_reg[i] <= (i == 0) ? in_valid : vld_reg[(i == 0) ? 0 : i - 1];
            end
        end
    end

    // Clip to +/-10, take |v|/2 in Q.24.
    logic signed [39:0] lim;
    logic signed [39:0] v_ext;
    logic signed [39:0] v_clip;
    logic        [39:0] mag;
    logic        [39:0] a_full;
    logic        [26:0] a0_reg;
    logic               neg0_reg;

    assign lim    = 40'(CLIP_INT) <<< FRAC_BITS;
    assign v_ext  = 40'($signed(in_arg));
    assign v_clip = (v_ext > lim) ? lim : ((v_ext < -lim) ? -lim : v_ext);
    assign mag    = v_clip[39] ? 40'(-v_clip) : 40'(v_clip);
    assign a_full = (mag << SL) >> SR;

    always_ff @(posedge aclk) begin
        if (ce) begin
            a0_reg   <= a_full[26:0];
            neg0_reg <= v_clip[39];
        end
    end

    // z squared.
    logic [53:0] a_sq;
    logic [28:0] z2_1_reg;
    logic [26:0] a1_reg;
    logic        neg1_reg;

    assign a_sq = 54'(a0_reg) * 54'(a0_reg);

    always_ff @(posedge aclk) begin
        if (ce) begin
            z2_1_reg <= a_sq[Q24+28:Q24];
            a1_reg   <= a0_reg;
            neg1_reg <= neg0_reg;
        end
    end

    // Innermost numerator and denominator terms.
    logic [33:0] n0_reg;
    logic [35:0] d0_reg;
    logic [28:0] z2_2_reg;
    logic [26:0] a2_reg;
    logic        neg2_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            n0_reg   <= (34'(PADE_N0) << Q24) + 34'(z2_1_reg);
            d0_reg   <= (36'(PADE_D0) << Q24) + 36'(z2_1_reg) * 36'(PADE_DZ);
            z2_2_reg <= z2_1_reg;
            a2_reg   <= a1_reg;
            neg2_reg <= neg1_reg;
        end
    end

    // Partial products of z2 times the first terms.
    logic [38:0] nh1_reg;
    logic [52:0] nl1_reg;
    logic [40:0] dh1_reg;
    logic [52:0] dl1_reg;
    logic [28:0] z2_3_reg;
    logic [26:0] a3_reg;
    logic        neg3_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            nh1_reg  <= 39'(z2_2_reg) * 39'(n0_reg[33:Q24]);
            nl1_reg  <= 53'(z2_2_reg) * 53'(n0_reg[Q24-1:0]);
            dh1_reg  <= 41'(z2_2_reg) * 41'(d0_reg[35:Q24]);
            dl1_reg  <= 53'(z2_2_reg) * 53'(d0_reg[Q24-1:0]);
            z2_3_reg <= z2_2_reg;
            a3_reg   <= a2_reg;
            neg3_reg <= neg2_reg;
        end
    end

    // Second terms.
    logic [39:0] n1_reg;
    logic [42:0] d1_reg;
    logic [28:0] z2_4_reg;
    logic [26:0] a4_reg;
    logic        neg4_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            n1_reg   <= (40'(PADE_N1) << Q24) + 40'(nh1_reg) + 40'(nl1_reg >> Q24);
            d1_reg   <= (43'(PADE_D1) << Q24) + 43'(dh1_reg) + 43'(dl1_reg >> Q24);
            z2_4_reg <= z2_3_reg;
            a4_reg   <= a3_reg;
            neg4_reg <= neg3_reg;
        end
    end

    // Partial products of z2 times the second terms.
    logic [44:0] nh2_reg;
    logic [52:0] nl2_reg;
    logic [47:0] dh2_reg;
    logic [52:0] dl2_reg;
    logic [26:0] a5_reg;
    logic        neg5_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            nh2_reg  <= 45'(z2_4_reg) * 45'(n1_reg[39:Q24]);
            nl2_reg  <= 53'(z2_4_reg) * 53'(n1_reg[Q24-1:0]);
            dh2_reg  <= 48'(z2_4_reg) * 48'(d1_reg[42:Q24]);
            dl2_reg  <= 53'(z2_4_reg) * 53'(d1_reg[Q24-1:0]);
            a5_reg   <= a4_reg;
            neg5_reg <= neg4_reg;
        end
    end

    // Outer numerator polynomial and full denominator.
    logic [47:0] n2_reg;
    logic [47:0] den6_reg;
    logic [26:0] a6_reg;
    logic        neg6_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            n2_reg   <= (48'(PADE_N2) << Q24) + 48'(nh2_reg) + 48'(nl2_reg >> Q24);
            den6_reg <= (48'(PADE_D2) << Q24) + 48'(dh2_reg) + 48'(dl2_reg >> Q24);
            a6_reg   <= a5_reg;
            neg6_reg <= neg5_reg;
        end
    end

    // Partial products of z times the numerator polynomial.
    logic [50:0] ah_reg;
    logic [50:0] al_reg;
    logic [47:0] den7_reg;
    logic        neg7_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            ah_reg   <= 51'(a6_reg) * 51'(n2_reg[47:Q24]);
            al_reg   <= 51'(a6_reg) * 51'(n2_reg[Q24-1:0]);
            den7_reg <= den6_reg;
            neg7_reg <= neg6_reg;
        end
    end

    // Full numerator.
    logic [47:0] num8_reg;
    logic [47:0] den8_reg;
    logic        neg8_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            num8_reg <= 48'(ah_reg) + 48'(al_reg >> Q24);
            den8_reg <= den7_reg;
            neg8_reg <= neg7_reg;
        end
    end

    // tanh in Q.32 by long division of the trimmed numerator and denominator.
    logic           dv_valid;
    logic [QNW-1:0] dv_quo;
    logic           dv_neg;

    lqse_div #(
        .NW (QNW),
        .DW (QDW),
        .PW (1)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (vld_reg[NST-1]),
        .in_num    ({num8_reg[46:16], 32'd0}),
        .in_den    (den8_reg[46:16]),
        .in_pay    (neg8_reg),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_pay   (dv_neg)
    );

    // Probability = 1/2 +/- tanh/2, clamped to [1, 2^32-1].
    logic [QNW-2:0] half_th;
    logic [QNW-1:0] pos_sum;
    logic [31:0]    prob_next;
    logic [31:0]    prob_reg;
    logic           vld_out_reg;

    assign half_th = dv_quo[QNW-1:1];
    assign pos_sum = QNW'(half_th) + QNW'(32'h8000_0000);

    always_comb begin
        if (dv_neg) begin
            if (half_th >= (QNW-1)'(32'h8000_0000)) begin
                prob_next = 32'd1;
            end else begin
                prob_next = 32'h8000_0000 - half_th[31:0];
            end
        end else begin
            if (pos_sum > QNW'(32'hFFFF_FFFF)) begin
                prob_next = 32'hFFFF_FFFF;
            end else begin
                prob_next = pos_sum[31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_out_reg <= 1'b0;
        end else if (ce) begin
            vld_out_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            prob_reg <= prob_next;
        end
    end

    assign out_valid = vld_out_reg;
    assign out_prob  = prob_reg;

endmodule

`default_nettype wire

>>> src/logit_quote_spread_engine.sv
// Logit quote spread engine: one market state per beat in, one bid/ask pair out.
// Pipeline depth is set by the one-bit-per-stage dividers, the 32 log2 squaring
// stages and the sigmoid division pipeline.
// Throughput is one beat per cycle; the whole pipeline holds while the output
// beat waits. Reset clears only the valid bits of every stage.
// Depends on lqse_pkg, lqse_div, lqse_log1p and lqse_sigmoid.
`default_nettype none

module logit_quote_spread_engine
    import lqse_pkg::*;
#(
    parameter int FRAC_BITS = 20
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // logit_mid, inventory, volatility, risk_aversion, horizon, liquidity
    input  wire logic [191:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // bid_prob, ask_prob
    output logic [63:0]       m_tdata
);

    localparam int N1W  = FRAC_BITS + 31;
    localparam int LPW  = FRAC_BITS + 7;
    localparam int N2W  = LPW + FRAC_BITS;
    localparam int P1W  = 2 * WORD_W + 31;
    localparam int P2W  = 2 * WORD_W;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Q.F product rounded to nearest and saturated.
    function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b) + (64'sd1 <<< (FRAC_BITS - 1));
        return sat32(p >>> FRAC_BITS);
    endfunction

    // The whole pipeline advances unless the output beat is held.
    logic ce;
    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    logic signed [31:0] in_x, in_q, in_s, in_g, in_t, in_k;
    assign in_x = s_tdata[31:0];
    assign in_q = s_tdata[63:32];
    assign in_s = s_tdata[95:64];
    assign in_g = s_tdata[127:96];
    assign in_t = s_tdata[159:128];
    assign in_k = s_tdata[191:160];

    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;

    logic signed [31:0] x0_reg, q0_reg, s0_reg, g0_reg, t0_reg;
    logic        [30:0] k0_reg;
    logic signed [31:0] s2_1_reg, x1_reg, q1_reg, g1_reg, t1_reg;
    logic        [30:0] k1_reg;
    logic signed [31:0] vt2_reg, x2_reg, q2_reg, g2_reg;
    logic        [30:0] k2_reg;
    logic signed [31:0] risk3_reg, x3_reg, q3_reg, g3_reg;
    logic        [30:0] k3_reg;
    logic signed [31:0] qr4_reg, x4_reg, risk4_reg, g4_reg;
    logic        [30:0] k4_reg;
    logic signed [31:0] r5_reg, risk5_reg, g5_reg;
    logic        [30:0] k5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (ce) begin
            v0_reg <= s_tvalid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // Clamp gamma, tau and k, then the risk chain: sigma^2, times tau, times gamma,
    // and the reservation logit.
    always_ff @(posedge aclk) begin
        if (ce) begin
            x0_reg <= in_x;
            q0_reg <= in_q;
            s0_reg <= in_s;
            g0_reg <= in_g[31] ? 32'sd0 : in_g;
            t0_reg <= in_t[31] ? 32'sd0 : in_t;
            k0_reg <= (in_k < 32'sd1) ? 31'd1 : in_k[30:0];

            s2_1_reg <= mulq(s0_reg, s0_reg);
            x1_reg   <= x0_reg;
            q1_reg   <= q0_reg;
            g1_reg   <= g0_reg;
            t1_reg   <= t0_reg;
            k1_reg   <= k0_reg;

            vt2_reg <= mulq(s2_1_reg, t1_reg);
            x2_reg  <= x1_reg;
            q2_reg  <= q1_reg;
            g2_reg  <= g1_reg;
            k2_reg  <= k1_reg;

            risk3_reg <= mulq(g2_reg, vt2_reg);
            x3_reg    <= x2_reg;
            q3_reg    <= q2_reg;
            g3_reg    <= g2_reg;
            k3_reg    <= k2_reg;

            qr4_reg   <= mulq(q3_reg, risk3_reg);
            x4_reg    <= x3_reg;
            risk4_reg <= risk3_reg;
            g4_reg    <= g3_reg;
            k4_reg    <= k3_reg;

            r5_reg    <= sat32(64'(x4_reg) - 64'(qr4_reg));
            risk5_reg <= risk4_reg;
            g5_reg    <= g4_reg;
            k5_reg    <= k4_reg;
        end
    end

    // gamma / k in Q.F.
    logic           d1_valid;
    logic [N1W-1:0] d1_quo;
    logic [P1W-1:0] d1_pay;

    lqse_div #(
        .NW (N1W),
        .DW (31),
        .PW (P1W)
    ) u_div_ratio (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (v5_reg),
        .in_num    ({g5_reg[30:0], {FRAC_BITS{1'b0}}}),
        .in_den    (k5_reg),
        .in_pay    ({r5_reg, risk5_reg, k5_reg}),
        .out_valid (d1_valid),
        .out_quo   (d1_quo),
        .out_pay   (d1_pay)
    );

    // log1p(gamma / k).
    logic           lg_valid;
    logic [LPW-1:0] lg_lp;
    logic [P1W-1:0] lg_pay;

    lqse_log1p #(
        .FRAC_BITS (FRAC_BITS),
        .PW        (P1W)
    ) u_log1p (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (d1_valid),
        .in_ratio  (d1_quo),
        .in_pay    (d1_pay),
        .out_valid (lg_valid),
        .out_lp    (lg_lp),
        .out_pay   (lg_pay)
    );

    // log1p term divided by k.
    logic           d2_valid;
    logic [N2W-1:0] d2_quo;
    logic [P2W-1:0] d2_pay;

    lqse_div #(
        .NW (N2W),
        .DW (31),
        .PW (P2W)
    ) u_div_spread (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (lg_valid),
        .in_num    ({lg_lp, {FRAC_BITS{1'b0}}}),
        .in_den    (lg_pay[30:0]),
        .in_pay    (lg_pay[P1W-1:31]),
        .out_valid (d2_valid),
        .out_quo   (d2_quo),
        .out_pay   (d2_pay)
    );

    // Half spread and the two sigmoid arguments.
    logic signed [31:0] d2_r, d2_risk;
    logic        [30:0] nl;
    logic signed [31:0] h6_reg, r6_reg;
    logic signed [31:0] bid_x7_reg, ask_x7_reg;

    assign d2_r    = d2_pay[P2W-1:WORD_W];
    assign d2_risk = d2_pay[WORD_W-1:0];
    assign nl      = (d2_quo[N2W-1:31] != '0) ? 31'h7FFF_FFFF : d2_quo[30:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else if (ce) begin
            v6_reg <= d2_valid;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            h6_reg     <= sat32(64'(d2_risk >>> 1) + 64'(nl));
            r6_reg     <= d2_r;
            bid_x7_reg <= sat32(64'(r6_reg) - 64'(h6_reg));
            ask_x7_reg <= sat32(64'(r6_reg) + 64'(h6_reg));
        end
    end

    // Bid and ask sigmoids run side by side; their last stage is the output.
    logic [31:0] bid_prob, ask_prob;

    lqse_sigmoid #(
        .FRAC_BITS (FRAC_BITS)
    ) u_sig_bid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (v7_reg),
        .in_arg    (bid_x7_reg),
        .out_valid (m_tvalid),
        .out_prob  (bid_prob)
    );

    lqse_sigmoid #(
        .FRAC_BITS (FRAC_BITS)
    ) u_sig_ask (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (v7_reg),
        .in_arg    (ask_x7_reg),
        .out_valid (),
        .out_prob  (ask_prob)
    );

    assign m_tdata = {ask_prob, bid_prob};

endmodule

`default_nettype wire
